/* sv/tsdpp_pkg.sv */
`default_nettype none

package tsdpp_pkg;

  typedef logic [7:0]         byte_t;
  typedef logic [14:0]        mag_t;
  typedef logic signed [15:0] pos_t;

  // Tag and symbol bytes (ASCII)
  localparam byte_t OpenFirst   = 8'h59;  // 'Y'
  localparam byte_t CloseFirst  = 8'h79;  // 'y'
  localparam byte_t OpenSecond  = 8'h42;  // 'B'
  localparam byte_t CloseSecond = 8'h62;  // 'b'
  localparam byte_t MinusByte   = 8'h2D;  // '-'
  localparam byte_t DigitLo     = 8'h30;  // '0'
  localparam byte_t DigitHi     = 8'h39;  // '9'

  localparam mag_t MagMax       = 15'h7FFF;
  // Sentinel -74: minus sign with magnitude 74
  localparam mag_t SentinelMag  = 15'd74;

  // Configuration port
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic RegAttackSel    = 1'b0;  // register index, from paddr[2]
  localparam logic AttackSelReset  = 1'b1;

  typedef struct packed {
    logic done;   // field completed on this byte
    pos_t held;   // held value after this byte
  } chan_status_t;

endpackage

`default_nettype wire

/* sv/tsdpp_chan.sv */
`default_nettype none

module tsdpp_chan (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      step_i,
  input  wire tsdpp_pkg::byte_t    byte_i,
  input  wire tsdpp_pkg::byte_t    open_tag_i,
  input  wire tsdpp_pkg::byte_t    close_tag_i,
  output tsdpp_pkg::chan_status_t  status_o
);
  import tsdpp_pkg::*;

  logic open_q, open_d;
  logic closed_q, closed_d;
  logic minus_q, minus_d;
  mag_t mag_q, mag_d;
  pos_t held_q, held_d;

  logic        open_n, closed_n;
  logic [18:0] mag_ext;
  logic [18:0] mag_sum;
  pos_t        value;

  assign open_n   = open_q | (byte_i == open_tag_i);
  assign closed_n = closed_q | (byte_i == close_tag_i);

  // mag * 10 + digit, as shifts and adds
  assign mag_ext = {4'b0, mag_q};
  assign mag_sum = (mag_ext << 3) + (mag_ext << 1) + {15'b0, byte_i[3:0]};

  assign value = minus_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});

  always_comb begin
    open_d   = open_n;
    closed_d = closed_n;
    minus_d  = minus_q;
    mag_d    = mag_q;
    held_d   = held_q;
    status_o.done = 1'b0;
    if (open_n && !closed_n) begin
      if (byte_i inside {[DigitLo:DigitHi]}) begin
        mag_d = (mag_sum > {4'b0, MagMax}) ? MagMax : mag_sum[14:0];
      end else if (byte_i == MinusByte) begin
        minus_d = 1'b1;
      end
    end
    if (open_n && closed_n) begin
      status_o.done = 1'b1;
      // keep the held value on the sentinel
      if (!(minus_q && mag_q == SentinelMag)) begin
        held_d = value;
      end
      open_d   = 1'b0;
      closed_d = 1'b0;
      minus_d  = 1'b0;
      mag_d    = '0;
    end
    status_o.held = held_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= 1'b0;
      closed_q <= 1'b0;
      minus_q  <= 1'b0;
      mag_q    <= '0;
      held_q   <= '0;
    end else if (step_i) begin
      open_q   <= open_d;
      closed_q <= closed_d;
      minus_q  <= minus_d;
      mag_q    <= mag_d;
      held_q   <= held_d;
    end
  end

endmodule

`default_nettype wire

/* sv/two_tag_signed_decimal_packet_parser.sv */
// Two-tag signed decimal packet parser. Each input transfer carries one received
// ASCII byte; two independent field parsers watch the stream, one framed by
// 'Y' ... 'y' and one by 'B' ... 'b'. Digits accumulate into a magnitude that
// saturates at 32767, a '-' makes the field negative, and an empty field
// yields 0. A closing tag seen before its opening tag is remembered, so the
// next opening tag completes that field at once with 0. A completed value of
// -74 is a sentinel and leaves the channel's held value untouched. After
// every second completed field (either channel) one output transfer is
// produced: attack_position is the held value of the attack channel and
// defend_position the negated held value of the other channel; register 0
// (attack_is_first_tag, APB address 0, reset 1) selects 'Y' as attack when
// set, 'B' otherwise. Timing: a byte is held in the input register, is
// parsed by one short combinational pass and the result lands in the
// output register, which drives output valid; one byte is taken every
// cycle while the output side keeps up.
// The output register is the only buffer: when it holds an untaken result,
// the parse step stalls and the input register fills, after which the input
// side stalls as well. Write the configuration only while the block is idle.

`default_nettype none

module two_tag_signed_decimal_packet_parser (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // byte input
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire tsdpp_pkg::byte_t         rx_byte_i,
  // result output
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output tsdpp_pkg::pos_t               attack_position_o,
  output tsdpp_pkg::pos_t               defend_position_o,
  // APB configuration
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire [tsdpp_pkg::CfgAddrW-1:0] paddr,
  input  wire [tsdpp_pkg::CfgDataW-1:0] pwdata,
  output logic [tsdpp_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);
  import tsdpp_pkg::*;

  // Configuration register
  logic attack_first_q;
  logic cfg_write;

  // Input register
  logic  in_valid_q;
  byte_t byte_q;

  // Output register
  logic out_valid_q;
  pos_t attack_q, attack_d;
  pos_t defend_q, defend_d;

  // Completion count: only one completion can be pending between results
  logic       pending_q, pending_d;
  logic [1:0] count;
  logic       emit;
  logic       step;

  chan_status_t first_st, second_st;

  // ---------------------------------------------------------------------------
  // APB: zero wait states, one register at address 0
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == RegAttackSel);

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegAttackSel) begin
      prdata[0] = attack_first_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_first_q <= AttackSelReset;
    end else if (cfg_write) begin
      attack_first_q <= pwdata[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: parse the held byte whenever the output register can take a
  // result; the input register refills in the same cycle.
  // ---------------------------------------------------------------------------
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Field parsers
  // ---------------------------------------------------------------------------
  tsdpp_chan u_first (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (byte_q),
    .open_tag_i  (OpenFirst),
    .close_tag_i (CloseFirst),
    .status_o    (first_st)
  );

  tsdpp_chan u_second (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (byte_q),
    .open_tag_i  (OpenSecond),
    .close_tag_i (CloseSecond),
    .status_o    (second_st)
  );

  // Count completions; emit on reaching two and clear the count
  assign count     = {1'b0, pending_q} + {1'b0, first_st.done} + {1'b0, second_st.done};
  assign emit      = count[1];
  assign pending_d = emit ? 1'b0 : count[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
    end else if (step) begin
      pending_q <= pending_d;
    end
  end

  // Select attack and defend from the updated held values
  always_comb begin
    if (attack_first_q) begin
      attack_d = first_st.held;
      defend_d = -second_st.held;
    end else begin
      attack_d = second_st.held;
      defend_d = -first_st.held;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: load a new result, else drop it once transferred
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      attack_q <= attack_d;
      defend_q <= defend_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign attack_position_o = attack_q;
  assign defend_position_o = defend_q;

endmodule

`default_nettype wire

/* sv/tsdpp_checker.sv */
`default_nettype none

module tsdpp_checker (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           in_ready_o,
  input wire                           out_valid_o,
  input wire                           out_ready_i,
  input wire tsdpp_pkg::pos_t          attack_position_o,
  input wire tsdpp_pkg::pos_t          defend_position_o,
  input wire                           psel,
  input wire                           penable,
  input wire                           pwrite,
  input wire [tsdpp_pkg::CfgAddrW-1:0] paddr,
  input wire [tsdpp_pkg::CfgDataW-1:0] pwdata,
  input wire [tsdpp_pkg::CfgDataW-1:0] prdata,
  input wire                           pready
);
  import tsdpp_pkg::*;

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(attack_position_o)
      && $stable(defend_position_o))
    else $error("result changed while stalled");

  // With no result waiting, the input side never stalls
  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  // Positions stay within the saturated range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> attack_position_o != 16'sh8000 && defend_position_o != 16'sh8000)
    else $error("position out of range");

  // A configuration write reads back
  a_cfg_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && (paddr[2] == RegAttackSel)
      |=> (paddr[2] != RegAttackSel) || (prdata[0] == $past(pwdata[0])))
    else $error("configuration readback mismatch");

endmodule

bind two_tag_signed_decimal_packet_parser tsdpp_checker u_tsdpp_checker (.*);

`default_nettype wire
